// File: src/mhpq_pkg.sv
// Shared constants, types and codes of the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    // Heap depth and derived widths.
    localparam int CAPACITY    = 128;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 8;
    localparam int OUT_W       = STATUS_W + KEY_W + COUNT_OUT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Bit positions of the result fields in the output tdata.
    localparam int OUT_STATUS_LSB  = 0;
    localparam int OUT_REMOVED_LSB = STATUS_W;
    localparam int OUT_COUNT_LSB   = STATUS_W + KEY_W;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [IDX_W-1:0]        idx_t;

    // Operation codes carried in the input tuser.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // One finished result on its way to the output register.
    typedef struct packed {
        status_t                status;
        key_t                   removed_key;
        logic [COUNT_OUT_W-1:0] count_after;
    } result_t;

    // Request from the sequencer to the key memory.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        addr_t raddr;
    } ram_req_t;

endpackage

// File: src/mhpq_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/mhpq_cmp.sv
// Shared signed key comparator used by both sift directions.
`timescale 1ns / 1ps

module mhpq_cmp
    import mhpq_pkg::*;
(
    input  key_t a,
    input  key_t b,
    output logic lt
);

    // Signed two's complement less-than.
    assign lt = (a < b);

endmodule

// File: src/mhpq_ctrl.sv
// Sequencer that walks the heap one level at a time around a shared comparator.
`timescale 1ns / 1ps

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  op_t      in_op,
    input  key_t     in_key,
    output logic     in_ready,
    input  logic     out_free,
    output logic     res_valid,
    output result_t  res,
    output ram_req_t ram_req,
    input  key_t     ram_rdata
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_UP_CHECK = 9'b000000010,
        ST_UP_CMP   = 9'b000000100,
        ST_DEL_ROOT = 9'b000001000,
        ST_DEL_LAST = 9'b000010000,
        ST_DN_CHECK = 9'b000100000,
        ST_DN_LEFT  = 9'b001000000,
        ST_DN_RIGHT = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    addr_t   pos_reg, pos_next;
    key_t    key_reg, key_next;
    key_t    best_key_reg, best_key_next;
    logic    best_left_reg, best_left_next;
    cnt_t    cnt_reg, cnt_next;
    status_t status_reg, status_next;
    key_t    removed_reg, removed_next;

    key_t  cmp_a;
    key_t  cmp_b;
    logic  cmp_lt;
    addr_t parent_addr;
    idx_t  left_idx;
    idx_t  right_idx;
    idx_t  cnt_idx;

    // Index arithmetic around the current hole position.
    assign parent_addr = addr_t'((pos_reg - addr_t'(1)) >> 1);
    assign left_idx    = idx_t'({pos_reg, 1'b1});
    assign right_idx   = left_idx + idx_t'(1);
    assign cnt_idx     = idx_t'(cnt_reg);

    // Operand selection for the shared comparator.
    always_comb
    begin
        if (state_reg == ST_UP_CMP)
        begin
            cmp_a = key_reg;
            cmp_b = ram_rdata;
        end
        else if (state_reg == ST_DN_LEFT)
        begin
            cmp_a = ram_rdata;
            cmp_b = key_reg;
        end
        else
        begin
            cmp_a = ram_rdata;
            cmp_b = best_key_reg;
        end
    end

    mhpq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    // Next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        best_key_next  = best_key_reg;
        best_left_next = best_left_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        ram_req        = '0;
        res_valid      = 1'b0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // The root is read speculatively so a delete finds it next cycle.
                ram_req.raddr = '0;
                if (in_valid)
                begin
                    removed_next = '0;
                    status_next  = STAT_OK;
                    if (in_op == OP_INSERT)
                    begin
                        if (cnt_reg >= cnt_t'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            key_next   = in_key;
                            pos_next   = addr_t'(cnt_reg);
                            cnt_next   = cnt_reg + cnt_t'(1);
                            state_next = ST_UP_CHECK;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DEL_ROOT;
                        end
                    end
                end
            end

            // Sift up: stop at the root, otherwise fetch the parent.
            ST_UP_CHECK:
            begin
                if (pos_reg == '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = key_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    ram_req.raddr = parent_addr;
                    state_next    = ST_UP_CMP;
                end
            end

            // Move the parent down into the hole while it is strictly greater.
            ST_UP_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_lt)
                begin
                    ram_req.wdata = ram_rdata;
                    pos_next      = parent_addr;
                    state_next    = ST_UP_CHECK;
                end
                else
                begin
                    ram_req.wdata = key_reg;
                    state_next    = ST_DONE;
                end
            end

            // The root arrives; fetch the last key.
            ST_DEL_ROOT:
            begin
                removed_next  = ram_rdata;
                ram_req.raddr = addr_t'(cnt_reg - cnt_t'(1));
                state_next    = ST_DEL_LAST;
            end

            // The last key becomes the one sifted down from the root.
            ST_DEL_LAST:
            begin
                key_next   = ram_rdata;
                cnt_next   = cnt_reg - cnt_t'(1);
                pos_next   = '0;
                state_next = ST_DN_CHECK;
            end

            // Sift down: stop at a leaf, otherwise fetch the left child.
            ST_DN_CHECK:
            begin
                if (left_idx >= cnt_idx)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = key_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    ram_req.raddr = addr_t'(left_idx);
                    state_next    = ST_DN_LEFT;
                end
            end

            // Left child arrives; keep the smaller of it and the moving key.
            ST_DN_LEFT:
            begin
                if (cmp_lt)
                begin
                    best_key_next  = ram_rdata;
                    best_left_next = 1'b1;
                end
                else
                begin
                    best_key_next  = key_reg;
                    best_left_next = 1'b0;
                end
                ram_req.raddr = addr_t'(right_idx);
                state_next    = ST_DN_RIGHT;
            end

            // Right child arrives; the strictly smallest moves up into the hole.
            ST_DN_RIGHT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if ((right_idx < cnt_idx) && cmp_lt)
                begin
                    ram_req.wdata = ram_rdata;
                    pos_next      = addr_t'(right_idx);
                    state_next    = ST_DN_CHECK;
                end
                else if (best_left_reg)
                begin
                    ram_req.wdata = best_key_reg;
                    pos_next      = addr_t'(left_idx);
                    state_next    = ST_DN_CHECK;
                end
                else
                begin
                    ram_req.wdata = key_reg;
                    state_next    = ST_DONE;
                end
            end

            // Hand the result over once the output register has room.
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.removed_key = removed_reg;
    assign res.count_after = COUNT_OUT_W'(cnt_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        best_key_reg  <= best_key_next;
        best_left_reg <= best_left_next;
        status_reg    <= status_next;
        removed_reg   <= removed_next;
    end

endmodule

// File: src/min_heap_priority_queue_core.sv
// Top level of the min-heap priority queue: key memory, sequencer, output register.
//
// Usage: each input transaction on the s_ side carries one operation in s_tuser
// (0 insert s_tdata as a signed key, 1 delete and return the minimum). Every
// transaction yields exactly one result on the m_ side with a status, the
// removed key and the key count afterward. The heap holds up to CAPACITY keys.
// The block takes one operation at a time: s_tready is high only while the
// sequencer is idle. Each heap level costs memory reads through the single
// read port of the key RAM, and one pass through the shared comparator per read.
// A refused operation goes straight to its result without touching the memory.
// The result appears on m_tvalid at the same edge at which the sequencer returns
// to idle, and s_tready is high again from that same edge on.
// A finished result sits in an output register; if the receiver stalls, the
// sequencer holds its next result until the register is taken, so nothing is
// lost. Reset empties the heap and the output register; memory contents are
// left as they are and only entries below the count are ever used.
`timescale 1ns / 1ps

module min_heap_priority_queue_core
    import mhpq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [KEY_W-1:0]       s_tdata,   // [31:0] key_in
    input  logic                   s_tuser,   // [0] op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] status, [33:2] removed_key,
                                              // [41:34] count_after, rest zero
);

    ram_req_t ram_req;
    key_t     ram_rdata;
    logic     res_valid;
    result_t  res;
    logic     out_free;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (op_t'(s_tuser)),
        .in_key    (key_t'(s_tdata)),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TDATA_W'({res.count_after, res.removed_key, res.status});
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/mhpq_chk.sv
// Port-level checker for the min-heap priority queue, bound to the top level.
`timescale 1ns / 1ps

module mhpq_chk
    import mhpq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0]    out_status;
    logic [KEY_W-1:0]       out_removed;
    logic [COUNT_OUT_W-1:0] out_count;

    assign out_status  = m_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign out_removed = m_tdata[OUT_REMOVED_LSB +: KEY_W];
    assign out_count   = m_tdata[OUT_COUNT_LSB +: COUNT_OUT_W];

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The block is busy in the cycle after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a transaction back to back");

    // A refused insert only happens with a full heap.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status == STAT_FULL) |->
            (out_count == COUNT_OUT_W'(CAPACITY)) && (out_removed == '0))
        else $error("full status with a wrong count");

    // A refused delete only happens with an empty heap.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status == STAT_EMPTY) |->
            (out_count == '0) && (out_removed == '0))
        else $error("empty status with a wrong count or key");

endmodule

bind min_heap_priority_queue_core mhpq_chk u_mhpq_chk (.*);
